// ===== src/assert_macros.svh =====
// Assertion macros shared by the generator RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted (active low)
`define XSR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds across reset
`define XSR_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define XSR_ASSERT(lbl, clk, rstn, prop, msg)
`define XSR_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== src/xsr256_pkg.sv =====
// Shared types, constants and update functions for the xoshiro256** generator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package xsr256_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned POLY_W = WORD_W * NUM_WORDS;
    localparam int unsigned COUNT_W = $clog2(POLY_W);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] gen_state_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        OP_NEXT      = 2'd0,
        OP_JUMP      = 2'd1,
        OP_LONG_JUMP = 2'd2,
        OP_LOAD      = 2'd3
    } op_e;

    // Jump polynomials, word 0 in the low bits: bit n is polynomial bit n
    localparam logic [POLY_W-1:0] JUMP_POLY = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };
    localparam logic [POLY_W-1:0] LONG_JUMP_POLY = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    localparam int unsigned SHIFT_T = 17;
    localparam int unsigned ROT_S3 = 45;
    localparam int unsigned ROT_OUT = 7;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // item accepted this cycle
        logic scale;    // finish the star-star output
        logic step;     // one jump step
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_step;  // jump bit counter at its final position
    } dp_status_t;

    function automatic word_t rotl(input word_t x, input int unsigned k);
        rotl = (x << k) | (x >> (WORD_W - k));
    endfunction

    // One state advance: xor, shift and rotate update
    function automatic gen_state_t advance(input gen_state_t s);
        gen_state_t n;
        word_t t;
        t = s[1] << SHIFT_T;
        n[2] = s[2] ^ s[0];
        n[3] = s[3] ^ s[1];
        n[1] = s[1] ^ n[2];
        n[0] = s[0] ^ n[3];
        n[2] = n[2] ^ t;
        n[3] = rotl(n[3], ROT_S3);
        advance = n;
    endfunction

    // x * 5 as shift and add
    function automatic word_t mul5(input word_t x);
        mul5 = x + (x << 2);
    endfunction

    // rotl(p, 7) * 9 as rotate, shift and add
    function automatic word_t finish_out(input word_t p);
        word_t r;
        r = rotl(p, ROT_OUT);
        finish_out = r + (r << 3);
    endfunction

endpackage
`default_nettype wire

// ===== src/xsr256_datapath.sv =====
// Datapath: generator state, jump accumulator, bit counter and output register.
// Depends on xsr256_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module xsr256_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire xsr256_pkg::dp_cmd_t    cmd,
    input  wire logic [1:0]             s_op,
    input  wire logic [1:0]             s_seed_index,
    input  wire logic [63:0]            s_seed_value,
    output xsr256_pkg::dp_status_t      status,
    output logic [63:0]                 random_value
);

    xsr256_pkg::gen_state_t gen_reg, gen_next;
    xsr256_pkg::gen_state_t accum_reg, accum_next;
    xsr256_pkg::count_t     count_reg, count_next;
    xsr256_pkg::word_t      prod_reg, prod_next;
    xsr256_pkg::word_t      rv_reg, rv_next;
    logic                   long_reg, long_next;

    logic                   poly_bit;
    xsr256_pkg::gen_state_t acc_mix;

    // Polynomial bit for this step and the accumulator with it applied
    always_comb begin
        poly_bit = long_reg ? xsr256_pkg::LONG_JUMP_POLY[count_reg]
                            : xsr256_pkg::JUMP_POLY[count_reg];
        acc_mix  = accum_reg ^ (poly_bit ? gen_reg : '0);
    end

    assign status.last_step = (count_reg == '1);

    // Next-state logic
    always_comb begin
        gen_next   = gen_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        prod_next  = prod_reg;
        rv_next    = rv_reg;
        long_next  = long_reg;
        if (cmd.capture) begin
            rv_next = '0;
            unique case (xsr256_pkg::op_e'(s_op))
                xsr256_pkg::OP_NEXT: begin
                    prod_next = xsr256_pkg::mul5(gen_reg[1]);
                    gen_next  = xsr256_pkg::advance(gen_reg);
                end
                xsr256_pkg::OP_JUMP, xsr256_pkg::OP_LONG_JUMP: begin
                    accum_next = '0;
                    count_next = '0;
                    long_next  = (xsr256_pkg::op_e'(s_op) == xsr256_pkg::OP_LONG_JUMP);
                end
                xsr256_pkg::OP_LOAD: begin
                    gen_next[s_seed_index] = s_seed_value;
                end
                default: begin
                    gen_next = gen_reg;
                end
            endcase
        end else if (cmd.scale) begin
            rv_next = xsr256_pkg::finish_out(prod_reg);
        end else if (cmd.step) begin
            count_next = count_reg + 1'b1;
            if (status.last_step) begin
                // final step: accumulated value replaces the state
                gen_next   = acc_mix;
                accum_next = '0;
            end else begin
                gen_next   = xsr256_pkg::advance(gen_reg);
                accum_next = acc_mix;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg   <= '0;
            accum_reg <= '0;
            count_reg <= '0;
        end else begin
            gen_reg   <= gen_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        rv_reg   <= rv_next;
        long_reg <= long_next;
    end

    assign random_value = rv_reg;

    `XSR_ASSERT(a_count_wraps, aclk, aresetn, cmd.step && status.last_step |=> count_reg == '0, "jump counter did not wrap")
    `XSR_ASSERT(a_load_zero, aclk, aresetn, cmd.capture && s_op != xsr256_pkg::OP_NEXT |=> rv_reg == '0, "non-next op left a nonzero result")
    `XSR_ASSERT(a_one_cmd, aclk, aresetn, $onehot0({cmd.capture, cmd.scale, cmd.step}), "overlapping datapath commands")

endmodule
`default_nettype wire

// ===== src/xsr256_ctrl.sv =====
// Controller state machine: handshakes and sequencing of output and jump steps.
// Depends on xsr256_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module xsr256_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_op,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire xsr256_pkg::dp_status_t status,
    output xsr256_pkg::dp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_JUMP,
        ST_DONE
    } state_e;

    state_e state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);

    // Commands to the datapath
    always_comb begin
        cmd.capture = s_valid && s_ready;
        cmd.scale   = (state_reg == ST_SCALE);
        cmd.step    = (state_reg == ST_JUMP);
    end

    // Transitions
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (xsr256_pkg::op_e'(s_op))
                        xsr256_pkg::OP_NEXT:      state_next = ST_SCALE;
                        xsr256_pkg::OP_JUMP:      state_next = ST_JUMP;
                        xsr256_pkg::OP_LONG_JUMP: state_next = ST_JUMP;
                        xsr256_pkg::OP_LOAD:      state_next = ST_DONE;
                        default:                  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCALE: state_next = ST_DONE;
            ST_JUMP: begin
                if (status.last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `XSR_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> s_ready && !m_valid, "not idle after reset")
    `XSR_ASSERT(a_next_latency, aclk, aresetn, s_valid && s_ready && s_op == xsr256_pkg::OP_NEXT |-> ##2 m_valid, "next output not ready two cycles after accept")
    `XSR_ASSERT(a_jump_busy, aclk, aresetn, s_valid && s_ready && (s_op == xsr256_pkg::OP_JUMP || s_op == xsr256_pkg::OP_LONG_JUMP) |=> !s_ready && !m_valid, "jump did not hold the block busy")

endmodule
`default_nettype wire

// ===== src/xoshiro256ss_generator_with_jump.sv =====
// Top level of the xoshiro256** generator with jump and long jump.
// Depends on xsr256_pkg, xsr256_ctrl and xsr256_datapath.
`default_nettype none
// One item in, one item out. The block takes one item at a time: s_ready is
// high only while it is idle, and drops from acceptance until the result is
// taken. Op 0 (next output) advances the state and registers s1*5 on
// acceptance, then forms rotl(.,7)*9 in its scale state and presents the
// result. Op 3 (seed load) presents a zero result in the cycle after
// acceptance. Ops 1 and 2 (jump, long jump) step the state once per cycle
// through all 256 polynomial bits and then present a zero result. No
// clearing pass after reset: the state resets to zero and must be seeded
// nonzero by op 3 writes.
module xoshiro256ss_generator_with_jump (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [1:0]  s_seed_index,
    input  wire logic [63:0] s_seed_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_random_value
);

    xsr256_pkg::dp_cmd_t    cmd;
    xsr256_pkg::dp_status_t status;

    xsr256_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    xsr256_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_op         (s_op),
        .s_seed_index (s_seed_index),
        .s_seed_value (s_seed_value),
        .status       (status),
        .random_value (m_random_value)
    );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the xoshiro256** generator with jump and long jump.
// Depends on xsr256_pkg for the op codes; carries its own prediction of the generator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_COUNT      = 500;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 300;
    localparam int IDLE_LIMIT      = 4000;

    // Jump polynomials, bit n of the vector is polynomial bit n
    localparam logic [255:0] JUMP_TAPS = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };
    localparam logic [255:0] LONG_JUMP_TAPS = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    // Directed item: known marks a result that is typed in rather than predicted
    typedef struct packed {
        xsr256_pkg::op_e op;
        logic [1:0]      idx;
        logic [63:0]     val;
        logic            known;
        logic [63:0]     want;
    } vec_t;

    localparam int NUM_VECS = 24;
    localparam vec_t DIRECTED [NUM_VECS] = '{
        // unseeded: all-zero state is a fixed point
        '{xsr256_pkg::OP_NEXT,      2'd0, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_JUMP,      2'd3, 64'hffffffffffffffff, 1'b1, 64'h0},
        '{xsr256_pkg::OP_LONG_JUMP, 2'd1, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_NEXT,      2'd2, 64'hffffffffffffffff, 1'b1, 64'h0},
        // seed every word, field extremes
        '{xsr256_pkg::OP_LOAD,      2'd0, 64'h0000000000000001, 1'b1, 64'h0},
        '{xsr256_pkg::OP_LOAD,      2'd1, 64'hffffffffffffffff, 1'b1, 64'h0},
        '{xsr256_pkg::OP_LOAD,      2'd2, 64'h8000000000000000, 1'b1, 64'h0},
        '{xsr256_pkg::OP_LOAD,      2'd3, 64'h0123456789abcdef, 1'b1, 64'h0},
        '{xsr256_pkg::OP_NEXT,      2'd0, 64'h0,                1'b0, 64'h0},
        '{xsr256_pkg::OP_NEXT,      2'd3, 64'hffffffffffffffff, 1'b0, 64'h0},
        '{xsr256_pkg::OP_JUMP,      2'd0, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_NEXT,      2'd0, 64'h0,                1'b0, 64'h0},
        '{xsr256_pkg::OP_LONG_JUMP, 2'd2, 64'h5555555555555555, 1'b1, 64'h0},
        '{xsr256_pkg::OP_NEXT,      2'd1, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0},
        // zero word 1: the output depends on word 1 alone
        '{xsr256_pkg::OP_LOAD,      2'd1, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_NEXT,      2'd0, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_LOAD,      2'd1, 64'hffffffffffffffff, 1'b1, 64'h0},
        '{xsr256_pkg::OP_NEXT,      2'd0, 64'h0,                1'b0, 64'h0},
        // back to the all-zero state by seeding zeros
        '{xsr256_pkg::OP_LOAD,      2'd0, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_LOAD,      2'd1, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_LOAD,      2'd2, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_LOAD,      2'd3, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_NEXT,      2'd0, 64'h0,                1'b1, 64'h0},
        '{xsr256_pkg::OP_JUMP,      2'd0, 64'h0,                1'b1, 64'h0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [1:0]  s_seed_index;
    logic [63:0] s_seed_value;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_random_value;

    logic [63:0] pred_words [4];
    logic [63:0] random_value_q [$];
    int          errors;
    int          idle_cycles;
    bit          steady;
    bit          hold_off_req;

    xoshiro256ss_generator_with_jump u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_seed_index   (s_seed_index),
        .s_seed_value   (s_seed_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value)
    );

    always #1 aclk = ~aclk;

    // ---- generator prediction ----

    function automatic logic [63:0] rot64(input logic [63:0] x, input int k);
        logic [127:0] twice;
        twice = {x, x} << k;
        return twice[127:64];
    endfunction

    // Star-star output of the current state, then one state advance
    function automatic logic [63:0] step_words();
        logic [63:0] scaled;
        logic [63:0] shifted;
        scaled  = pred_words[1] * 64'd5;
        scaled  = rot64(scaled, 7) * 64'd9;
        shifted = pred_words[1] << 17;
        pred_words[2] ^= pred_words[0];
        pred_words[3] ^= pred_words[1];
        pred_words[1] ^= pred_words[2];
        pred_words[0] ^= pred_words[3];
        pred_words[2] ^= shifted;
        pred_words[3] = rot64(pred_words[3], 45);
        return scaled;
    endfunction

    // 256 advances, xor-collecting the state at each set polynomial bit
    function automatic void jump_words(input logic [255:0] taps);
        logic [63:0] acc [4];
        logic [63:0] discard;
        for (int w = 0; w < 4; w++) acc[w] = '0;
        for (int n = 0; n < 256; n++) begin
            if (taps[n]) begin
                for (int w = 0; w < 4; w++) acc[w] ^= pred_words[w];
            end
            discard = step_words();
        end
        for (int w = 0; w < 4; w++) pred_words[w] = acc[w];
    endfunction

    function automatic logic [63:0] predict_random_value(input xsr256_pkg::op_e op,
                                                         input logic [1:0] idx,
                                                         input logic [63:0] val);
        case (op)
            xsr256_pkg::OP_NEXT: begin
                return step_words();
            end
            xsr256_pkg::OP_JUMP: begin
                jump_words(JUMP_TAPS);
            end
            xsr256_pkg::OP_LONG_JUMP: begin
                jump_words(LONG_JUMP_TAPS);
            end
            default: begin
                pred_words[idx] = val;
            end
        endcase
        return '0;
    endfunction

    function automatic logic [63:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(7);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // ---- input side ----

    // Offer one item, wait for it to be taken and queue its expected result
    task automatic send_item(input xsr256_pkg::op_e op, input logic [1:0] idx,
                             input logic [63:0] val, input logic known,
                             input logic [63:0] want);
        logic [63:0] predicted;
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 13) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_op         = op;
        s_seed_index = idx;
        s_seed_value = val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_random_value(op, idx, val);
        random_value_q.push_back(known ? want : predicted);
    endtask

    // ---- result side ----

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // long stall so the block backs up into its input
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            m_ready = steady || ($urandom_range(99) >= 13);
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (random_value_q.size() == 0) begin
                $display("%0t: unexpected result random_value=%h", $time, m_random_value);
                errors++;
            end else begin
                want = random_value_q.pop_front();
                if (m_random_value !== want) begin
                    $display("%0t: random_value mismatch expected %h actual %h",
                             $time, want, m_random_value);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, random_value_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ---- main sequence ----

    initial begin
        int              sent;
        int              pick;
        bit              hold_done;
        bit              drain_done;
        xsr256_pkg::op_e op;

        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = xsr256_pkg::OP_NEXT;
        s_seed_index = 2'd0;
        s_seed_value = 64'h0;
        errors       = 0;
        idle_cycles  = 0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        sent         = 0;
        for (int w = 0; w < 4; w++) pred_words[w] = '0;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        for (int i = 0; i < NUM_VECS; i++) begin
            send_item(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].val,
                      DIRECTED[i].known, DIRECTED[i].want);
        end

        // reseed with random content before the random run
        for (int w = 0; w < 4; w++) begin
            send_item(xsr256_pkg::OP_LOAD, w[1:0], {$urandom, $urandom}, 1'b0, '0);
        end

        while (sent < ITEM_COUNT) begin
            steady = (sent >= 300 && sent < 400);
            if (!hold_done && sent >= 100) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && sent >= 250) begin
                // let the block run dry before offering more
                @(negedge aclk);
                s_valid = 1'b0;
                while (random_value_q.size() != 0) @(posedge aclk);
                drain_done = 1'b1;
            end

            pick = $urandom_range(99);
            if (pick < 6) begin
                // full reseed sequence
                for (int w = 0; w < 4; w++) begin
                    send_item(xsr256_pkg::OP_LOAD, w[1:0], rand_word(), 1'b0, '0);
                end
                sent += 4;
            end else begin
                if (pick < 10)      op = xsr256_pkg::OP_JUMP;
                else if (pick < 14) op = xsr256_pkg::OP_LONG_JUMP;
                else if (pick < 28) op = xsr256_pkg::OP_LOAD;
                else                op = xsr256_pkg::OP_NEXT;
                send_item(op, 2'($urandom_range(3)), rand_word(), 1'b0, '0);
                sent++;
            end
        end
        steady = 1'b0;

        @(negedge aclk);
        s_valid = 1'b0;

        while (random_value_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
